>>> hdl/amm_pkg.sv
// amm_pkg: shared types, constants and helper functions for the audio matrix mixer.
// Used by every module of the mixer and by its checker; depends on nothing.
`default_nettype none

package amm_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int LANE_W     = 16;
    localparam int CH_W       = 3;
    localparam int CFG_W      = 64;
    localparam int REG_IDX_W  = 3;
    localparam int MODE_W     = 3;
    localparam int IN_CH      = 2;
    localparam int OUT_CH     = 8;
    localparam int FIFO_DEPTH = 2;

    // Register reset values
    localparam logic [LANE_W-1:0] MASTER_RESET = 16'd20676;
    localparam logic [CFG_W-1:0]  GAIN_RESET   = 64'h50C4_50C4_50C4_50C4;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_MIX_ENABLE       = 3'd0,
        REG_OUTPUT_MODE      = 3'd1,
        REG_MASTER_GAIN      = 3'd2,
        REG_LEFT_GAINS_LOW   = 3'd3,
        REG_LEFT_GAINS_HIGH  = 3'd4,
        REG_RIGHT_GAINS_LOW  = 3'd5,
        REG_RIGHT_GAINS_HIGH = 3'd6
    } t_reg_idx;

    // Speaker layouts
    typedef enum logic [MODE_W-1:0] {
        MODE_2_0_0 = 3'd0,
        MODE_2_2_0 = 3'd1,
        MODE_2_2_1 = 3'd2,
        MODE_3_2_0 = 3'd3,
        MODE_3_2_1 = 3'd4
    } t_out_mode;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]            channel_index;
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic                       clipped;
        logic                       last_channel;
    } t_result;

    // Settings seen by the channel engine
    typedef struct packed {
        logic              mix_enable;
        logic [GAIN_W-1:0] master_gain;
        logic [CFG_W-1:0]  left_lo;
        logic [CFG_W-1:0]  left_hi;
        logic [CFG_W-1:0]  right_lo;
        logic [CFG_W-1:0]  right_hi;
    } t_mix_cfg;

    // One queued frame: samples plus its final channel number
    typedef struct packed {
        t_in_item        item;
        logic [CH_W-1:0] last_idx;
    } t_q_entry;

    // Final channel number of a frame for a layout; unknown layouts act as 3/2/1
    function automatic logic [CH_W-1:0] frame_last(input logic [MODE_W-1:0] mode);
        logic [CH_W:0] n;
        unique case (t_out_mode'(mode))
            MODE_2_0_0:             n = 4'd2;
            MODE_2_2_0:             n = 4'd4;
            MODE_2_2_1, MODE_3_2_0: n = 4'd5;
            default:                n = 4'd6;
        endcase
        if (n > (CH_W+1)'(OUT_CH)) n = (CH_W+1)'(OUT_CH);
        return CH_W'(n - 4'd1);
    endfunction

    // Gain lane for one output channel out of a low/high pair of packed words
    function automatic logic [GAIN_W-1:0] gain_lane(input logic [CFG_W-1:0] lo,
                                                    input logic [CFG_W-1:0] hi,
                                                    input logic [CH_W-1:0]  ch);
        logic [CFG_W-1:0] w;
        w = ch[2] ? hi : lo;
        return w[ch[1:0]*LANE_W +: GAIN_W];
    endfunction

endpackage

`default_nettype wire

>>> hdl/amm_front.sv
// amm_front: register file and frame intake of the audio matrix mixer.
// Takes a frame, works out its channel count and hands it to the queue. Uses amm_pkg.
`default_nettype none

module amm_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire amm_pkg::t_in_item                 i_item,
    input  wire logic                              i_queue_full,
    input  wire logic                              i_cfg_we,
    input  wire logic [amm_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [amm_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                   o_push,
    output amm_pkg::t_q_entry                      o_entry,
    output amm_pkg::t_mix_cfg                      o_cfg
);
    import amm_pkg::*;

    logic                r_mix_enable;
    logic [MODE_W-1:0]   r_output_mode;
    logic [LANE_W-1:0]   r_master_gain;
    logic [CFG_W-1:0]    r_left_lo;
    logic [CFG_W-1:0]    r_left_hi;
    logic [CFG_W-1:0]    r_right_lo;
    logic [CFG_W-1:0]    r_right_hi;

    // Register writes; index 7 is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_enable  <= 1'b1;
            r_output_mode <= MODE_2_2_0;
            r_master_gain <= MASTER_RESET;
            r_left_lo     <= GAIN_RESET;
            r_left_hi     <= GAIN_RESET;
            r_right_lo    <= GAIN_RESET;
            r_right_hi    <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MIX_ENABLE:       r_mix_enable  <= i_cfg_data[0];
                REG_OUTPUT_MODE:      r_output_mode <= i_cfg_data[MODE_W-1:0];
                REG_MASTER_GAIN:      r_master_gain <= i_cfg_data[LANE_W-1:0];
                REG_LEFT_GAINS_LOW:   r_left_lo     <= i_cfg_data;
                REG_LEFT_GAINS_HIGH:  r_left_hi     <= i_cfg_data;
                REG_RIGHT_GAINS_LOW:  r_right_lo    <= i_cfg_data;
                REG_RIGHT_GAINS_HIGH: r_right_hi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Intake: an item enters whenever the queue has room
    always_comb begin
        o_push           = i_start && !i_queue_full;
        o_entry.item     = i_item;
        o_entry.last_idx = frame_last(r_output_mode);
    end

    // Settings for the channel engine
    always_comb begin
        o_cfg.mix_enable  = r_mix_enable;
        o_cfg.master_gain = r_master_gain[GAIN_W-1:0];
        o_cfg.left_lo     = r_left_lo;
        o_cfg.left_hi     = r_left_hi;
        o_cfg.right_lo    = r_right_lo;
        o_cfg.right_hi    = r_right_hi;
    end

endmodule

`default_nettype wire

>>> hdl/amm_queue.sv
// amm_queue: frame queue between intake and channel engine, with a registered head.
// Small memory plus a head register that the engine reads directly. Uses amm_pkg.
`default_nettype none

module amm_queue #(
    parameter int DEPTH = amm_pkg::FIFO_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire amm_pkg::t_q_entry i_entry,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_head_valid,
    output amm_pkg::t_q_entry      o_head
);
    import amm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_q_entry        r_mem [DEPTH];
    t_q_entry        r_head;
    logic            r_head_valid;
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            load;

    // Refill the head when it is empty or being taken
    assign load = (r_count != '0) && (!r_head_valid || i_pop);
    assign n_count = r_count + CW'(i_push) - CW'(load);

    // Storage and head register
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
        if (load)   r_head <= r_mem[r_rd];
    end

    // Pointers, fill count, head valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr         <= '0;
            r_rd         <= '0;
            r_count      <= '0;
            r_head_valid <= 1'b0;
        end else begin
            if (i_push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            if (load)   r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            r_count <= n_count;
            if (load)       r_head_valid <= 1'b1;
            else if (i_pop) r_head_valid <= 1'b0;
        end
    end

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = r_head_valid;
    assign o_head       = r_head;

endmodule

`default_nettype wire

>>> hdl/amm_back.sv
// amm_back: channel engine of the audio matrix mixer.
// Steps through the channels of the head frame, one per cycle, through a four-stage
// multiply, round and saturate pipeline. Uses amm_pkg.
`default_nettype none

module amm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_head_valid,
    input  wire amm_pkg::t_q_entry i_head,
    input  wire amm_pkg::t_mix_cfg i_cfg,
    output logic                   o_pop,
    output logic                   o_strobe,
    output amm_pkg::t_result       o_result
);
    import amm_pkg::*;

    localparam int PRD_W  = SAMPLE_W + GAIN_W + 1;   // sample times one gain
    localparam int SUM_W  = PRD_W + 1;
    localparam int MAG_W  = SAMPLE_W + GAIN_W;       // magnitude of the matrix sum
    localparam int FULL_W = MAG_W + GAIN_W;          // after the master gain
    localparam int SHIFT  = 2 * (GAIN_W - 1);
    localparam int Q_W    = FULL_W + 1 - SHIFT;
    localparam logic [FULL_W:0]      HALF    = (FULL_W+1)'(1) << (SHIFT - 1);
    localparam logic [Q_W-1:0]       SMAX_Q  = {{(Q_W-SAMPLE_W+1){1'b0}},
                                                {(SAMPLE_W-1){1'b1}}};
    localparam logic [Q_W-1:0]       SMIN_Q  = SMAX_Q + Q_W'(1);
    localparam logic [SAMPLE_W-1:0]  SMAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0]  SMIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Per-channel bookkeeping that rides along the pipeline
    typedef struct packed {
        logic                       valid;
        logic [CH_W-1:0]            idx;
        logic                       last;
        logic                       mix;
        logic signed [SAMPLE_W-1:0] byp;
    } t_tag;

    logic [CH_W-1:0]            r_chan;
    t_tag                       n_tag;
    t_tag                       r_s1_tag, r_s2_tag, r_s3_tag;
    logic signed [PRD_W-1:0]    r_s1_pl, r_s1_pr;
    logic signed [PRD_W-1:0]    n_pl, n_pr;
    logic                       r_s2_neg, r_s3_neg;
    logic [MAG_W-1:0]           r_s2_mag;
    logic signed [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]           abs_sum;
    logic [FULL_W-1:0]          r_s3_full;
    logic [FULL_W:0]            rnd;
    logic [Q_W-1:0]             q;
    logic [Q_W-1:0]             neg_q;
    t_result                    n_out;
    t_result                    r_out;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] sl, sr;
    logic signed [GAIN_W:0]     gl, gr;

    // Channel sequencer: one channel of the head frame per cycle
    assign o_pop = i_head_valid && (r_chan == i_head.last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
        end else if (i_head_valid) begin
            r_chan <= o_pop ? '0 : r_chan + CH_W'(1);
        end
    end

    // Stage 1 inputs: gain lookup, both products, bypass value
    always_comb begin
        sl = i_head.item.left_sample;
        sr = (IN_CH > 1) ? i_head.item.right_sample : '0;
        gl = {1'b0, gain_lane(i_cfg.left_lo, i_cfg.left_hi, r_chan)};
        gr = {1'b0, gain_lane(i_cfg.right_lo, i_cfg.right_hi, r_chan)};
        n_pl = sl * gl;
        n_pr = sr * gr;
        n_tag.valid = i_head_valid;
        n_tag.idx   = r_chan;
        n_tag.last  = o_pop;
        n_tag.mix   = i_cfg.mix_enable;
        if (r_chan == CH_W'(0))      n_tag.byp = sl;
        else if (r_chan == CH_W'(1)) n_tag.byp = sr;
        else                         n_tag.byp = '0;
    end

    // Stage 2 inputs: matrix sum split into sign and magnitude
    always_comb begin
        sum     = SUM_W'(r_s1_pl) + SUM_W'(r_s1_pr);
        abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    end

    // Stage 4 inputs: round half away from zero, then saturate
    always_comb begin
        rnd   = {1'b0, r_s3_full} + HALF;
        q     = Q_W'(rnd >> SHIFT);
        neg_q = -q;
        n_out.channel_index = r_s3_tag.idx;
        n_out.last_channel  = r_s3_tag.last;
        n_out.clipped       = 1'b0;
        if (!r_s3_tag.mix) begin
            n_out.mixed_sample = r_s3_tag.byp;
        end else if (r_s3_neg) begin
            if (q > SMIN_Q) begin
                n_out.mixed_sample = SMIN;
                n_out.clipped      = 1'b1;
            end else begin
                n_out.mixed_sample = neg_q[SAMPLE_W-1:0];
            end
        end else begin
            if (q > SMAX_Q) begin
                n_out.mixed_sample = SMAX;
                n_out.clipped      = 1'b1;
            end else begin
                n_out.mixed_sample = q[SAMPLE_W-1:0];
            end
        end
    end

    // Pipeline registers; only the valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag.valid <= 1'b0;
            r_s2_tag.valid <= 1'b0;
            r_s3_tag.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_s1_tag.valid <= n_tag.valid;
            r_s2_tag.valid <= r_s1_tag.valid;
            r_s3_tag.valid <= r_s2_tag.valid;
            r_out_valid    <= r_s3_tag.valid;
        end

        r_s1_tag.idx  <= n_tag.idx;
        r_s1_tag.last <= n_tag.last;
        r_s1_tag.mix  <= n_tag.mix;
        r_s1_tag.byp  <= n_tag.byp;
        r_s1_pl       <= n_pl;
        r_s1_pr       <= n_pr;

        r_s2_tag.idx  <= r_s1_tag.idx;
        r_s2_tag.last <= r_s1_tag.last;
        r_s2_tag.mix  <= r_s1_tag.mix;
        r_s2_tag.byp  <= r_s1_tag.byp;
        r_s2_neg      <= sum[SUM_W-1];
        r_s2_mag      <= abs_sum[MAG_W-1:0];

        r_s3_tag.idx  <= r_s2_tag.idx;
        r_s3_tag.last <= r_s2_tag.last;
        r_s3_tag.mix  <= r_s2_tag.mix;
        r_s3_tag.byp  <= r_s2_tag.byp;
        r_s3_neg      <= r_s2_neg;
        r_s3_full     <= r_s2_mag * i_cfg.master_gain;

        r_out         <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

>>> hdl/audio_matrix_mixer_core.sv
// audio_matrix_mixer_core: top level of the stereo to multichannel gain-matrix mixer.
// Instantiates amm_front, amm_queue and amm_back; uses amm_pkg.
//
//   channel   ports                                 transfer
//   -------   -----------------------------------   ------------------------------------
//   frame     start, busy, i_item                   taken at an edge with start && !busy
//   result    o_strobe, o_result                    one strobe per result, no back-pressure
//   config    i_cfg_we, i_cfg_index, i_cfg_data     written at an edge with i_cfg_we high
//
// A frame gives 2, 4, 5 or 6 results, one per cycle; a taken frame passes the queue
// memory, the head register and the engine pipeline before its first result appears.
// Frames are taken every cycle while the queue (QUEUE_DEPTH frames plus the head
// register) has room; busy rises only when the queue is full.
// Reset is synchronous and clears the registers to their documented values and
// empties the queue and pipeline.
`default_nettype none

module audio_matrix_mixer_core #(
    parameter int QUEUE_DEPTH = amm_pkg::FIFO_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire amm_pkg::t_in_item             i_item,
    output logic                               o_strobe,
    output amm_pkg::t_result                   o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [amm_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [amm_pkg::CFG_W-1:0]     i_cfg_data
);
    import amm_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      head_valid;
    t_q_entry  entry;
    t_q_entry  head;
    t_mix_cfg  cfg;

    amm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (i_item),
        .i_queue_full (queue_full),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_entry      (entry),
        .o_cfg        (cfg)
    );

    amm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    amm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_cfg        (cfg),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

    assign busy = queue_full;

endmodule

`default_nettype wire

>>> hdl/amm_checker.sv
// amm_checker: port-level assertions for audio_matrix_mixer_core, and the bind
// that attaches them. Uses amm_pkg.
`default_nettype none

module amm_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_strobe,
    input wire amm_pkg::t_result o_result
);
    import amm_pkg::*;

    // Channels of one frame come out back to back, in order
    a_channel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_channel |=>
            o_strobe && (o_result.channel_index == $past(o_result.channel_index) + 3'd1))
        else $error("channel sequence broken inside a frame");

    // Every layout has at least two channels
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.channel_index == 3'd0) |-> !o_result.last_channel)
        else $error("frame ended on channel 0");

    // A frame ends on a layout's final channel
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_channel |->
            (o_result.channel_index == 3'd1) || (o_result.channel_index == 3'd3) ||
            (o_result.channel_index == 3'd4) || (o_result.channel_index == 3'd5))
        else $error("frame ended on an impossible channel");

    // Clipped results sit at full scale
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.clipped |->
            (o_result.mixed_sample == 16'sh7FFF) || (o_result.mixed_sample == -16'sh8000))
        else $error("clipped result not at full scale");

    // Reset flushes the pipeline
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

bind audio_matrix_mixer_core amm_checker u_amm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

>>> sim/amm_mix_checker.sv
`timescale 1ns / 100ps
// amm_mix_checker: watches the frame, result and register ports of the mixer core,
// predicts the channel samples of every taken frame and compares them in order.
// Depends on amm_pkg for the item types, register indexes and layout codes.

module amm_mix_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  amm_pkg::t_in_item                  i_item,
    input  wire logic                          i_strobe,
    input  amm_pkg::t_result                   i_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [amm_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [amm_pkg::CFG_W-1:0]     i_cfg_data,
    output int                                 o_pending,
    output int                                 o_errors
);
    import amm_pkg::*;

    // Product of sample, lane gain and master gain carries 2*(GAIN_W-1) fraction bits
    localparam int                PROD_SHIFT = 2 * (GAIN_W - 1);
    localparam longint unsigned   ROUND_HALF = 64'd1 << (PROD_SHIFT - 1);
    localparam longint unsigned   POS_LIMIT  = (64'd1 << (SAMPLE_W - 1)) - 1;
    localparam logic [SAMPLE_W-1:0] POS_FULL = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] NEG_FULL = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Local copy of the register file
    logic              mix_on;
    logic [MODE_W-1:0] layout;
    logic [GAIN_W-1:0] master;
    logic [CFG_W-1:0]  left_lo, left_hi, right_lo, right_hi;

    t_result channel_q[$];
    int      errors = 0;

    // Channels per frame for a layout; unknown layouts give the widest one
    function automatic int layout_channels(input logic [MODE_W-1:0] m);
        int n;
        case (m)
            MODE_2_0_0:             n = 2;
            MODE_2_2_0:             n = 4;
            MODE_2_2_1, MODE_3_2_0: n = 5;
            default:                n = 6;
        endcase
        return (n > OUT_CH) ? OUT_CH : n;
    endfunction

    // Expected result for one output channel of a frame
    function automatic t_result mix_channel(input logic [CH_W-1:0] ch, input t_in_item it,
                                            input logic last);
        t_result         r;
        logic [CFG_W-1:0] lw, rw;
        longint          lgain, rgain, acc;
        longint unsigned mag, q;
        r.channel_index = ch;
        r.clipped       = 1'b0;
        r.last_channel  = last;
        if (!mix_on) begin
            // bypass: first two channels copy the inputs, the rest are silent
            if (ch == 0)      r.mixed_sample = it.left_sample;
            else if (ch == 1) r.mixed_sample = it.right_sample;
            else              r.mixed_sample = '0;
        end else begin
            lw    = ch[2] ? left_hi : left_lo;
            rw    = ch[2] ? right_hi : right_lo;
            lgain = longint'(lw[ch[1:0]*LANE_W +: GAIN_W]);
            rgain = longint'(rw[ch[1:0]*LANE_W +: GAIN_W]);
            acc   = longint'($signed(it.left_sample)) * lgain
                  + longint'($signed(it.right_sample)) * rgain;
            // sign and magnitude, round half away from zero
            mag = (acc < 0) ? -acc : acc;
            mag = mag * master;
            q   = (mag + ROUND_HALF) >> PROD_SHIFT;
            if (acc < 0) begin
                if (q > POS_LIMIT + 1) begin
                    r.mixed_sample = NEG_FULL;
                    r.clipped      = 1'b1;
                end else begin
                    r.mixed_sample = SAMPLE_W'(-longint'(q));
                end
            end else if (q > POS_LIMIT) begin
                r.mixed_sample = POS_FULL;
                r.clipped      = 1'b1;
            end else begin
                r.mixed_sample = SAMPLE_W'(q);
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] want,
                                        input logic [SAMPLE_W-1:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
        end
    endfunction

    // Register writes, frame acceptance and result checking, all on the edge
    always @(posedge i_clk) begin
        t_result want;
        int      n;
        if (!i_rst_n) begin
            mix_on   = 1'b1;
            layout   = MODE_2_2_0;
            master   = MASTER_RESET;
            left_lo  = GAIN_RESET;
            left_hi  = GAIN_RESET;
            right_lo = GAIN_RESET;
            right_hi = GAIN_RESET;
            channel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MIX_ENABLE:       mix_on   = i_cfg_data[0];
                    REG_OUTPUT_MODE:      layout   = i_cfg_data[MODE_W-1:0];
                    REG_MASTER_GAIN:      master   = i_cfg_data[GAIN_W-1:0];
                    REG_LEFT_GAINS_LOW:   left_lo  = i_cfg_data;
                    REG_LEFT_GAINS_HIGH:  left_hi  = i_cfg_data;
                    REG_RIGHT_GAINS_LOW:  right_lo = i_cfg_data;
                    REG_RIGHT_GAINS_HIGH: right_hi = i_cfg_data;
                    default: ;  // unused index, write dropped
                endcase
            end
            if (i_start && !i_busy) begin
                n = layout_channels(layout);
                for (int c = 0; c < n; c++)
                    channel_q.push_back(mix_channel(CH_W'(c), i_item, c == n - 1));
            end
            if (i_strobe) begin
                if (channel_q.size() == 0) begin
                    errors++;
                    $error("result on channel %0d with no frame outstanding",
                           i_result.channel_index);
                end else begin
                    want = channel_q.pop_front();
                    check_field("channel_index", want.channel_index, i_result.channel_index);
                    check_field("mixed_sample", want.mixed_sample, i_result.mixed_sample);
                    check_field("clipped", want.clipped, i_result.clipped);
                    check_field("last_channel", want.last_channel, i_result.last_channel);
                end
            end
        end
        o_pending <= channel_q.size();
        o_errors  <= errors;
    end

endmodule

>>> sim/tb_audio_matrix_mixer_core.sv
`timescale 1ns / 100ps
// tb_audio_matrix_mixer_core: stimulus and verdict for the mixer core; frames are
// sent under several register settings and checked by amm_mix_checker.
// Depends on amm_pkg, amm_mix_checker and the audio_matrix_mixer_core RTL.

module tb_audio_matrix_mixer_core;
    import amm_pkg::*;

    localparam int FRAME_TARGET   = 170;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_UNDEF_LO = 3'd5;
    localparam logic [MODE_W-1:0]    MODE_UNDEF_HI = 3'd7;
    localparam logic [GAIN_W-1:0]    UNITY_GAIN  = 16'h8000;
    localparam logic [GAIN_W-1:0]    HALF_GAIN   = 16'h4000;
    localparam logic [CFG_W-1:0]     UNITY_GAINS = {4{UNITY_GAIN}};
    localparam logic [CFG_W-1:0]     FULL_GAINS  = '1;
    localparam logic signed [SAMPLE_W-1:0] POS_FULL = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] NEG_FULL = 16'sh8000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    t_in_item             i_item      = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 busy;
    logic                 o_strobe;
    t_result              o_result;

    int pending;
    int errors;
    int frames_sent  = 0;
    int stall_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    audio_matrix_mixer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    amm_mix_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Watchdog: cycles in a row with no frame, result or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Extremes now and then, otherwise any 16-bit value
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return POS_FULL;
            1:       return NEG_FULL;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Send one frame; sender gap rate depends on how far the run has got
    task automatic push_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r);
        int idle_pct;
        idle_pct = (frames_sent < 60) ? 25 : (frames_sent < 120) ? 65 : 0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{left_sample: l, right_sample: r};
        do @(posedge i_clk); while (busy);
        frames_sent++;
    endtask

    // Stop sending and wait until every channel of every frame is out
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] mix_w, input logic [CFG_W-1:0] mode_w,
                                  input logic [CFG_W-1:0] gain_w,
                                  input logic [CFG_W-1:0] ll, input logic [CFG_W-1:0] lh,
                                  input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] rh);
        write_reg(REG_MIX_ENABLE, mix_w);
        write_reg(REG_OUTPUT_MODE, mode_w);
        write_reg(REG_MASTER_GAIN, gain_w);
        write_reg(REG_LEFT_GAINS_LOW, ll);
        write_reg(REG_LEFT_GAINS_HIGH, lh);
        write_reg(REG_RIGHT_GAINS_LOW, rl);
        write_reg(REG_RIGHT_GAINS_HIGH, rh);
        i_cfg_we <= 1'b0;
    endtask

    // Random register set; junk above the narrow fields checks the masking
    task automatic pick_settings();
        logic [CFG_W-1:0] w[4];
        logic [CFG_W-1:0] mix_w, mode_w, gain_w;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(4))
                0:       w[k] = FULL_GAINS;
                1:       w[k] = UNITY_GAINS;
                2:       w[k] = '0;
                default: w[k] = {$urandom, $urandom};
            endcase
        end
        mix_w     = {$urandom, $urandom};
        mix_w[0]  = ($urandom_range(9) != 0);
        mode_w    = {$urandom, $urandom};
        gain_w    = {$urandom, $urandom};
        case ($urandom_range(4))
            0:       gain_w[GAIN_W-1:0] = '1;
            1:       gain_w[GAIN_W-1:0] = UNITY_GAIN;
            2:       gain_w[GAIN_W-1:0] = '0;
            default: ;
        endcase
        apply_settings(mix_w, mode_w, gain_w, w[0], w[1], w[2], w[3]);
    endtask

    initial begin
        int burst;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 2/2/0 layout, all gains near -4 dB
        push_frame('0, '0);
        push_frame(POS_FULL, POS_FULL);
        push_frame(NEG_FULL, NEG_FULL);
        push_frame(POS_FULL, NEG_FULL);
        push_frame(NEG_FULL, POS_FULL);
        push_frame(16'sd1, -16'sd1);
        settle();

        // Full-scale gains on the 3/2/1 layout: saturation both ways
        apply_settings(64'd1, {61'd0, MODE_3_2_1}, {48'd0, 16'hFFFF},
                       FULL_GAINS, FULL_GAINS, FULL_GAINS, FULL_GAINS);
        push_frame(POS_FULL, POS_FULL);
        push_frame(NEG_FULL, NEG_FULL);
        push_frame(16'sd100, -16'sd100);
        push_frame(16'sd1, '0);
        settle();

        // Unity lanes, half master: ties round away from zero, exact negative full scale
        apply_settings(64'd1, {61'd0, MODE_2_2_1}, {48'd0, HALF_GAIN},
                       UNITY_GAINS, UNITY_GAINS, UNITY_GAINS, UNITY_GAINS);
        push_frame(16'sd1, '0);
        push_frame(-16'sd1, '0);
        push_frame(NEG_FULL, NEG_FULL);
        push_frame(POS_FULL, POS_FULL);
        settle();

        // Unity master: negative full scale reached without clipping, positive clips
        write_reg(REG_MASTER_GAIN, {48'd0, UNITY_GAIN});
        i_cfg_we <= 1'b0;
        push_frame(NEG_FULL, '0);
        push_frame(POS_FULL, 16'sd1);
        settle();

        // Bypass on the 2/0/0 layout, enable and mode words carry junk upper bits
        apply_settings(64'hFFFF_FFFF_FFFF_FFFE, {61'h1FFF_FFFF_FFFF_FFFF, MODE_2_0_0},
                       '1, '0, '1, '0, '1);
        push_frame(POS_FULL, NEG_FULL);
        push_frame(-16'sd1, 16'sd1);
        settle();

        // Undefined layouts act as 3/2/1; write to an unused index is dropped
        write_reg(REG_UNUSED, '1);
        apply_settings(64'd0, {61'd0, MODE_UNDEF_HI}, 64'd0, '0, '0, '0, '0);
        push_frame(POS_FULL, NEG_FULL);
        settle();
        apply_settings(64'd1, {61'd0, MODE_UNDEF_LO}, 64'hFFFF_FFFF_0000_8000,
                       64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                       64'h8000_4000_2000_1000, 64'h0001_FFFF_7FFF_0000);
        push_frame(rand_sample(), rand_sample());
        push_frame(rand_sample(), rand_sample());
        settle();
        apply_settings(64'd1, {61'd0, MODE_3_2_0}, {48'd0, 16'hC000},
                       {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
        push_frame(rand_sample(), rand_sample());
        push_frame(rand_sample(), rand_sample());
        settle();

        // Random settings, each followed by a burst of random frames
        while (frames_sent < FRAME_TARGET) begin
            pick_settings();
            burst = $urandom_range(8, 24);
            repeat (burst) push_frame(rand_sample(), rand_sample());
            settle();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/amm_pkg.sv
hdl/amm_front.sv
hdl/amm_queue.sv
hdl/amm_back.sv
hdl/audio_matrix_mixer_core.sv
hdl/amm_checker.sv
sim/amm_mix_checker.sv
sim/tb_audio_matrix_mixer_core.sv
